// ===== rtl/mbds_pkg.sv =====
// ----------------------------------------------------------------------------
// mbds_pkg: shared types and constants for the mip chain box downsampler
// Field widths of the configuration port and the pixel channels.
// ----------------------------------------------------------------------------
package mbds_pkg;

  localparam int unsigned CfgW    = 13;  // widest configuration register
  localparam int unsigned ChW     = 3;   // channel_count register
  localparam int unsigned NumCh   = 4;
  localparam int unsigned PixW    = 8;
  localparam int unsigned LevelW  = 4;   // mip_level output
  localparam int unsigned PosW    = 11;  // out_col / out_row outputs
  localparam int unsigned CfgIdxW = 2;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_IMAGE_WIDTH   = 2'd0,
    CFG_IMAGE_HEIGHT  = 2'd1,
    CFG_CHANNEL_COUNT = 2'd2
  } cfg_idx_e;

  typedef logic [PixW-1:0] pix_t [NumCh];

endpackage

// ===== rtl/mipmap_box_downsample_chain.sv =====
// ----------------------------------------------------------------------------
// mipmap_box_downsample_chain: streaming mip chain builder, 2x2 box filters
//
// Base pixels enter on the in_* channel (valid/ready) in raster order. Every
// finished pixel of levels 1 and up leaves on the out_* channel, lowest level
// first, tagged with level, column and row. chain_done marks the 1x1 level.
// Configuration is a plain write port (cfg_we_i, cfg_idx_i, cfg_data_i); any
// write restarts the image at position zero. Write only while idle.
// One shared level stage walks the cascade: per level it passes S_STAGE,
// then S_VERT for the line store read on odd rows, then the output
// hand-off in S_OUT for each result. A pixel that finishes nothing goes
// from S_STAGE straight back to ready in S_IDLE.
// The block takes one pixel at a time: in_ready_o is low from acceptance
// until the cascade for that pixel ends. A stalled receiver holds the result
// in the output register and freezes the cascade.
// Reset sets width 1, height 1, four channels; the line store needs no clear.
// ----------------------------------------------------------------------------
module mipmap_box_downsample_chain #(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned MAX_HEIGHT = 4096,
  parameter int unsigned MAX_LEVELS = 12
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [mbds_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [mbds_pkg::CfgW-1:0]       cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [mbds_pkg::PixW-1:0]       in_c0_i,
  input  logic [mbds_pkg::PixW-1:0]       in_c1_i,
  input  logic [mbds_pkg::PixW-1:0]       in_c2_i,
  input  logic [mbds_pkg::PixW-1:0]       in_c3_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [mbds_pkg::LevelW-1:0]     mip_level_o,
  output logic [mbds_pkg::PosW-1:0]       out_col_o,
  output logic [mbds_pkg::PosW-1:0]       out_row_o,
  output logic [mbds_pkg::PixW-1:0]       out_c0_o,
  output logic [mbds_pkg::PixW-1:0]       out_c1_o,
  output logic [mbds_pkg::PixW-1:0]       out_c2_o,
  output logic [mbds_pkg::PixW-1:0]       out_c3_o,
  output logic                            chain_done_o
);

  localparam int unsigned MaxDim    = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int unsigned DW        = $clog2(MaxDim + 1);
  localparam int unsigned LineDepth = MAX_WIDTH + MAX_LEVELS;
  localparam int unsigned AW        = $clog2(LineDepth);
  localparam int unsigned LW        = $clog2(MAX_LEVELS + 1);
  localparam int unsigned LIW       = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
  localparam int unsigned NC        = mbds_pkg::NumCh;
  localparam int unsigned PW        = mbds_pkg::PixW;
  localparam int unsigned SW        = PW + 1;   // stored pair sum
  localparam int unsigned TW        = PW + 2;   // full 2x2 sum

  typedef enum logic [1:0] {S_IDLE, S_STAGE, S_VERT, S_OUT} state_e;

  state_e                    state_q;
  logic [mbds_pkg::CfgW-1:0] width_q, height_q;
  logic [mbds_pkg::ChW-1:0]  chans_q;
  logic [DW-1:0]             col_q [MAX_LEVELS];
  logic [DW-1:0]             row_q [MAX_LEVELS];
  mbds_pkg::pix_t            pend_q [MAX_LEVELS];
  logic [LW-1:0]             lvl_q;
  logic [DW-1:0]             hw_q, hh_q;
  logic [AW-1:0]             base_q;
  mbds_pkg::pix_t            v_q;
  logic [TW-1:0]             ps_q [NC];
  logic [1:0]                sh_q;
  logic [DW-1:0]             ocol_q, orow_q;
  logic [mbds_pkg::PixW-1:0] oc_q [NC];
  logic                      odone_q;

  logic [NC*SW-1:0] line_mem [LineDepth];
  logic [NC*SW-1:0] line_rd_q;

  // ---- configuration decode, clamped sizes ---------------------------------
  logic [DW-1:0] w_cl, h_cl;
  logic [2:0]    ch_cl;
  always_comb begin
    if (width_q == '0) w_cl = DW'(1);
    else if ({1'b0, width_q} > (mbds_pkg::CfgW + 1)'(MAX_WIDTH)) w_cl = DW'(MAX_WIDTH);
    else w_cl = DW'(width_q);
    if (height_q == '0) h_cl = DW'(1);
    else if ({1'b0, height_q} > (mbds_pkg::CfgW + 1)'(MAX_HEIGHT)) h_cl = DW'(MAX_HEIGHT);
    else h_cl = DW'(height_q);
    if (chans_q == '0) ch_cl = 3'd1;
    else if (chans_q > 3'd4) ch_cl = 3'd4;
    else ch_cl = chans_q;
  end

  // ---- shared level stage ---------------------------------------------------
  logic [LIW-1:0]  li;
  logic [DW-1:0]   x, y, nw, nh, col_n, row_n, hcol;
  logic            active, h_even, h_pair, v_even, v_drop, h_drop;
  logic [TW-1:0]   ps [NC];
  logic [AW:0]     idx_full;
  logic [AW-1:0]   idx;
  logic            mem_we, mem_re;

  always_comb begin
    li     = lvl_q[LIW-1:0];
    x      = col_q[li];
    y      = row_q[li];
    nw     = ((hw_q >> 1) == '0) ? DW'(1) : (hw_q >> 1);
    nh     = ((hh_q >> 1) == '0) ? DW'(1) : (hh_q >> 1);
    active = (lvl_q < LW'(MAX_LEVELS)) && ((hw_q > DW'(1)) || (hh_q > DW'(1)));
    // advance this level's raster position
    if ((x + DW'(1)) >= hw_q) begin
      col_n = '0;
      row_n = ((y + DW'(1)) >= hh_q) ? '0 : y + DW'(1);
    end else begin
      col_n = x + DW'(1);
      row_n = y;
    end
    h_pair = hw_q >= DW'(2);
    h_drop = h_pair && ({1'b0, x} >= {nw, 1'b0});
    h_even = h_pair && !x[0];
    hcol   = h_pair ? (x >> 1) : '0;
    for (int c = 0; c < NC; c++) begin
      ps[c] = h_pair ? TW'(pend_q[li][c]) + TW'(v_q[c]) : TW'(v_q[c]);
    end
    idx_full = {1'b0, base_q} + (AW + 1)'(hcol);
    idx      = (idx_full >= (AW + 1)'(LineDepth)) ? AW'(LineDepth - 1) : idx_full[AW-1:0];
    v_drop   = (hh_q >= DW'(2)) && ({1'b0, y} >= {nh, 1'b0});
    v_even   = (hh_q >= DW'(2)) && !y[0];
    mem_we   = (state_q == S_STAGE) && active && !h_drop && !h_even && !v_drop && v_even;
    mem_re   = (state_q == S_STAGE) && active && !h_drop && !h_even && !v_drop && !v_even
               && (hh_q >= DW'(2));
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      for (int c = 0; c < NC; c++) line_mem[idx][c*SW +: SW] <= ps[c][SW-1:0];
    end
    if (mem_re) line_rd_q <= line_mem[idx];
  end

  // ---- sequencer ------------------------------------------------------------
  logic [PW-1:0] in_pix [NC];
  assign in_pix[0] = in_c0_i;
  assign in_pix[1] = in_c1_i;
  assign in_pix[2] = in_c2_i;
  assign in_pix[3] = in_c3_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      width_q  <= mbds_pkg::CfgW'(1);
      height_q <= mbds_pkg::CfgW'(1);
      chans_q  <= mbds_pkg::ChW'(4);
      for (int l = 0; l < MAX_LEVELS; l++) begin
        col_q[l] <= '0;
        row_q[l] <= '0;
      end
      lvl_q    <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (cfg_we_i) begin
            for (int l = 0; l < MAX_LEVELS; l++) begin
              col_q[l] <= '0;
              row_q[l] <= '0;
            end
            unique case (cfg_idx_i)
              mbds_pkg::CFG_IMAGE_WIDTH:   width_q  <= cfg_data_i;
              mbds_pkg::CFG_IMAGE_HEIGHT:  height_q <= cfg_data_i;
              mbds_pkg::CFG_CHANNEL_COUNT: chans_q  <= cfg_data_i[mbds_pkg::ChW-1:0];
              default: ;
            endcase
          end else if (in_valid_i) begin
            lvl_q  <= '0;
            hw_q   <= w_cl;
            hh_q   <= h_cl;
            base_q <= '0;
            for (int c = 0; c < NC; c++) begin
              v_q[c] <= (3'(c) < ch_cl) ? in_pix[c] : '0;
            end
            state_q <= S_STAGE;
          end
        end
        S_STAGE: begin
          if (!active) begin
            state_q <= S_IDLE;
          end else begin
            col_q[li] <= col_n;
            row_q[li] <= row_n;
            ocol_q    <= hcol;
            // a one-high level keeps y at zero, so this is row 0 there
            orow_q    <= y >> 1;
            odone_q   <= (nw == DW'(1)) && (nh == DW'(1));
            if (h_drop || v_drop) begin
              state_q <= S_IDLE;
            end else if (h_even) begin
              pend_q[li] <= v_q;   // hold left partner
              state_q    <= S_IDLE;
            end else if (v_even) begin
              state_q <= S_IDLE;
            end else if (hh_q >= DW'(2)) begin
              for (int c = 0; c < NC; c++) ps_q[c] <= ps[c];
              sh_q    <= h_pair ? 2'd2 : 2'd1;
              state_q <= S_VERT;
            end else begin
              for (int c = 0; c < NC; c++) begin
                oc_q[c] <= h_pair ? ps[c][PW:1] : ps[c][PW-1:0];
              end
              state_q <= S_OUT;
            end
          end
        end
        S_VERT: begin
          for (int c = 0; c < NC; c++) begin
            logic [TW-1:0] s;
            s = ps_q[c] + TW'(line_rd_q[c*SW +: SW]);
            oc_q[c] <= (sh_q == 2'd2) ? s[PW+1:2] : s[PW:1];
          end
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (out_ready_i) begin
            // pass the finished pixel on to the next level
            lvl_q  <= lvl_q + LW'(1);
            hw_q   <= nw;
            hh_q   <= nh;
            base_q <= base_q + AW'(nw);
            v_q    <= oc_q;
            state_q <= S_STAGE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o   = (state_q == S_IDLE) && !cfg_we_i;
  assign out_valid_o  = (state_q == S_OUT);
  assign mip_level_o  = mbds_pkg::LevelW'(lvl_q) + mbds_pkg::LevelW'(1);
  assign out_col_o    = mbds_pkg::PosW'(ocol_q);
  assign out_row_o    = mbds_pkg::PosW'(orow_q);
  assign out_c0_o     = oc_q[0];
  assign out_c1_o     = oc_q[1];
  assign out_c2_o     = oc_q[2];
  assign out_c3_o     = oc_q[3];
  assign chain_done_o = odone_q;

  a_ready_no_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !out_valid_o) else $error("ready while result pending");
  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (lvl_q < LW'(MAX_LEVELS))) else $error("level beyond cap");
  a_done_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && chain_done_o) |-> (out_col_o == '0 && out_row_o == '0))
    else $error("final level pixel not at origin");
  a_out_next_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i) |=> (state_q == S_STAGE))
    else $error("cascade did not resume");

endmodule
